// File: rtl/q31a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q31a_pkg
// Shared types and codes of the Q31 fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package q31a_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_DIV = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_WRAP    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam logic [31:0] Q31_MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_MAX_NEG = 32'h8000_0001;

  localparam int unsigned Q31_SHIFT = 31;
  localparam int unsigned NUM_W     = 32 + Q31_SHIFT;
  localparam int unsigned DIV_STEPS = NUM_W;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [31:0]      res;
    logic [1:0]       st;
    logic [63:0]      prod;
    logic [NUM_W-1:0] num;
    logic [31:0]      den;
    logic             qneg;
    logic             aneg;
    logic             bzero;
  } front_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [31:0]      res;
    logic [1:0]       st;
    logic [NUM_W-1:0] num;
    logic [31:0]      den;
    logic [31:0]      rem;
    logic [32:0]      quo;
    logic             sticky;
    logic             qneg;
    logic             aneg;
    logic             bzero;
  } div_t;

endpackage
`default_nettype wire

// File: rtl/q31_fixed_point_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q31_fixed_point_alu
// Q31 add, multiply and divide unit with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// path: input register, front register, divider step registers, result register, for every opcode
// throughput: one transfer per cycle unless out_tready stalls the pipeline; the 63-stage restoring divider sets depth
// each stage stalls only when full and its successor is blocked
// reset: synchronous active-low rst_n empties all pipeline stages
module q31_fixed_point_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  wire logic [1:0]  in_tuser,   // cmd [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // result [31:0]
  output logic [1:0]       out_tuser   // status [1:0]
);
  import q31a_pkg::*;

  localparam int unsigned NS = DIV_STEPS + 3;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  logic [1:0]  cmd_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  front_t      front_nxt;
  front_t      front_r;
  div_t        div_in;
  div_t        step_in  [DIV_STEPS];
  div_t        step_out [DIV_STEPS];
  div_t        div_r    [DIV_STEPS];
  div_t        last;
  logic [31:0] res_nxt;
  logic [1:0]  st_nxt;
  logic [31:0] res_r;
  logic [1:0]  st_r;

  // stall chain
  assign en[NS-1] = !vld_r[NS-1] || out_tready;
  genvar gi;
  generate
    for (gi = 0; gi < NS - 1; gi++) begin : g_en
      assign en[gi] = !vld_r[gi] || en[gi+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd_r <= in_tuser;
      a_r   <= in_tdata[31:0];
      b_r   <= in_tdata[63:32];
    end
  end

  q31a_front u_front (
    .cmd       (cmd_r),
    .operand_a (a_r),
    .operand_b (b_r),
    .front     (front_nxt)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      front_r <= front_nxt;
    end
  end

  // product scaling and divider seed
  always_comb begin
    div_in.cmd    = front_r.cmd;
    div_in.res    = front_r.res;
    div_in.st     = front_r.st;
    if (front_r.cmd == CMD_MUL) begin
      div_in.res = front_r.prod[62:31];
      div_in.st  = (front_r.prod[63] != front_r.prod[62]) ? ST_WRAP : ST_OK;
    end
    div_in.num    = front_r.num;
    div_in.den    = front_r.den;
    div_in.rem    = '0;
    div_in.quo    = '0;
    div_in.sticky = 1'b0;
    div_in.qneg   = front_r.qneg;
    div_in.aneg   = front_r.aneg;
    div_in.bzero  = front_r.bzero;
  end

  generate
    for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
      if (gi == 0) begin : g_first
        assign step_in[gi] = div_in;
      end else begin : g_next
        assign step_in[gi] = div_r[gi-1];
      end
      q31a_div_step u_step (
        .d_in  (step_in[gi]),
        .d_out (step_out[gi])
      );
      always_ff @(posedge clk) begin
        if (en[gi+2]) begin
          div_r[gi] <= step_out[gi];
        end
      end
    end
  endgenerate

  // sign fixup, divide-by-zero saturation and wrap detection
  assign last = div_r[DIV_STEPS-1];
  always_comb begin
    res_nxt = last.res;
    st_nxt  = last.st;
    if (last.cmd == CMD_DIV) begin
      if (last.bzero) begin
        res_nxt = last.aneg ? Q31_MAX_NEG : Q31_MAX_POS;
        st_nxt  = ST_DIVZERO;
      end else begin
        res_nxt = last.qneg ? (32'd0 - last.quo[31:0]) : last.quo[31:0];
        if (last.sticky || last.quo[32] ||
            (last.quo[31] && (!last.qneg || (last.quo[30:0] != 31'd0)))) begin
          st_nxt = ST_WRAP;
        end else begin
          st_nxt = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = res_r;
  assign out_tuser  = st_r;

  a_divz_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DIVZERO) |->
      (out_tdata == Q31_MAX_POS) || (out_tdata == Q31_MAX_NEG))
    else $error("divide by zero result not saturated");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_SAT) |->
      (out_tdata == Q31_MAX_POS) || (out_tdata == Q31_MAX_NEG))
    else $error("saturated add result out of range");

  a_add_status: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] && (front_r.cmd == CMD_ADD) |->
      (front_r.st == ST_OK) || (front_r.st == ST_SAT))
    else $error("add produced a wrap or divide status");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && !en[NS-2] |=> vld_r[NS-2] == $past(vld_r[NS-2]))
    else $error("stalled stage lost its item");

endmodule
`default_nettype wire

// File: rtl/q31a_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q31a_front
// Saturating add, signed multiply and divider operand preparation.
// ----------------------------------------------------------------------------
module q31a_front (
  input  wire logic [1:0]       cmd,
  input  wire logic [31:0]      operand_a,
  input  wire logic [31:0]      operand_b,
  output q31a_pkg::front_t      front
);
  import q31a_pkg::*;

  logic signed [32:0] sum;
  logic [31:0]        abs_a;
  logic [31:0]        abs_b;

  always_comb begin
    sum   = $signed({operand_a[31], operand_a}) + $signed({operand_b[31], operand_b});
    abs_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    abs_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;

    front.cmd = cmd;
    front.res = '0;
    front.st  = ST_OK;
    if (cmd == CMD_ADD) begin
      if (sum > $signed({1'b0, Q31_MAX_POS})) begin
        front.res = Q31_MAX_POS;
        front.st  = ST_SAT;
      end else if (sum < $signed({1'b1, Q31_MAX_NEG})) begin
        front.res = Q31_MAX_NEG;
        front.st  = ST_SAT;
      end else begin
        front.res = sum[31:0];
      end
    end
    front.prod  = 64'($signed(operand_a) * $signed(operand_b));
    front.num   = {abs_a, {Q31_SHIFT{1'b0}}};
    front.den   = abs_b;
    front.qneg  = operand_a[31] ^ operand_b[31];
    front.aneg  = operand_a[31];
    front.bzero = (operand_b == 32'd0);
  end

endmodule
`default_nettype wire

// File: rtl/q31a_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q31a_div_step
// One restoring division step: one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module q31a_div_step (
  input  wire q31a_pkg::div_t d_in,
  output q31a_pkg::div_t      d_out
);
  import q31a_pkg::*;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial = {d_in.rem, d_in.num[NUM_W-1]};
    diff  = trial - {1'b0, d_in.den};
    ge    = (trial >= {1'b0, d_in.den});

    d_out        = d_in;
    d_out.rem    = ge ? diff[31:0] : trial[31:0];
    d_out.num    = {d_in.num[NUM_W-2:0], 1'b0};
    d_out.quo    = {d_in.quo[31:0], ge};
    d_out.sticky = d_in.sticky | d_in.quo[32];
  end

endmodule
`default_nettype wire

// File: dv/q31_fixed_point_alu_tb.sv
// ----------------------------------------------------------------------------
// q31_fixed_point_alu_tb
// Self-checking testbench for the Q31 add, multiply and divide unit. Items are
// sent with random gaps and back-pressure. Each result is checked against a
// predictor run at input acceptance.
// ----------------------------------------------------------------------------
module q31_fixed_point_alu_tb;
  import q31a_pkg::*;

  localparam int LATENCY   = 66;
  localparam int WDOG_MAX  = 20000;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [31:0] res;
    logic [1:0]  st;
  } alu_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  alu_res_t pending_q[$];
  int       n_err;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_cycles;
  int       idle_count;

  q31_fixed_point_alu DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic alu_res_t q31_compute(logic [1:0] cmd, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] s;
    logic signed [63:0] p;
    logic signed [95:0] q;
    r.res = '0;
    r.st  = ST_OK;
    case (cmd)
      CMD_ADD: begin
        s = 64'(a) + 64'(b);
        if (s > 64'sh7FFF_FFFF) begin
          r.res = Q31_MAX_POS;
          r.st  = ST_SAT;
        end else if (s < -64'sh7FFF_FFFF) begin
          r.res = Q31_MAX_NEG;
          r.st  = ST_SAT;
        end else begin
          r.res = s[31:0];
        end
      end
      CMD_MUL: begin
        p = (64'(a) * 64'(b)) >>> Q31_SHIFT;
        r.res = p[31:0];
        if (p != 64'(signed'(p[31:0]))) r.st = ST_WRAP;
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.res = a[31] ? Q31_MAX_NEG : Q31_MAX_POS;
          r.st  = ST_DIVZERO;
        end else begin
          q = (96'(a) <<< Q31_SHIFT) / 96'(b);
          r.res = q[31:0];
          if (q != 96'(signed'(q[31:0]))) r.st = ST_WRAP;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_err++;
  endtask

  // one input transfer, gap before it as the idle rate asks
  task automatic send_op(logic [1:0] cmd, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(q31_compute(cmd, a, b));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand;
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(8)) - 4);
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    logic [31:0] ext[6];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0, 32'h1, 32'hFFFF_FFFF};
    send_op(CMD_ADD, 32'h8000_0000, 32'h0);
    send_op(CMD_ADD, 32'hC000_0000, 32'hC000_0000);
    send_op(CMD_ADD, 32'h7FFF_FFFF, 32'h1);
    send_op(CMD_ADD, 32'h1234_5678, 32'hFFFF_0000);
    send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send_op(CMD_DIV, 32'h0, 32'h0);
    send_op(CMD_DIV, 32'h8000_0000, 32'h0);
    send_op(CMD_DIV, 32'h1234_5678, 32'h0);
    send_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(CMD_DIV, 32'h4000_0000, 32'h7FFF_FFFF);
    send_op(CMD_DIV, 32'hC000_0000, 32'h2000_0000);
    send_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000);
    send_op(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_op(CMD_DIV, ext[i], ext[5 - i]);
    drain();
  endtask

  task automatic test_random(int n);
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(19) == 0) ? CMD_NOP : 2'($urandom_range(2));
      send_op(cmd, rand_operand(), rand_operand());
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    hold_cycles   = 300;
    test_random(120);
  endtask

  // result checker
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata !== want.res) report_mismatch("result", out_tdata, want.res);
        if (out_tuser !== want.st) report_mismatch("status", 32'(out_tuser), 32'(want.st));
      end
    end
  end

  // receiver stall, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WDOG_MAX) begin
      $display("[q31_fixed_point_alu] ERROR");
      $finish;
    end
  end

  initial begin
    n_err = 0; idle_count = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; out_tready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(80);
    send_idle_pct = 73; recv_stall_pct = 0;
    test_random(60);
    send_idle_pct = 0; recv_stall_pct = 73;
    test_random(60);
    send_idle_pct = 17; recv_stall_pct = 17;
    test_random(60);
    test_backpressure();
    repeat (LATENCY + 10) @(negedge clk);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("[q31_fixed_point_alu] OK");
    end else begin
      $display("[q31_fixed_point_alu] ERROR");
    end
    $finish;
  end
endmodule

// File: q31_fixed_point_alu.f
rtl/q31a_pkg.sv
rtl/q31a_front.sv
rtl/q31a_div_step.sv
rtl/q31_fixed_point_alu.sv
dv/q31_fixed_point_alu_tb.sv
